// File: rtl/config_line_tokenizer_unit_assert.svh
// Assertion macros for the line tokenizer. The user module provides clk and arst_n.
`ifndef CONFIG_LINE_TOKENIZER_UNIT_ASSERT_SVH
`define CONFIG_LINE_TOKENIZER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define CLT_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tokenizer check failed");

// Next-cycle implication.
`define CLT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tokenizer check failed");

`endif

// File: rtl/clt_pkg.sv
package clt_pkg;

	localparam int MAX_RESULTS = 4;
	localparam int IDX_W = $clog2(MAX_RESULTS);
	localparam int CNT_W = $clog2(MAX_RESULTS + 1);
	localparam int QUEUE_DEPTH_DEF = 2;

	localparam logic [1:0] KIND_CHAR = 2'd0;
	localparam logic [1:0] KIND_END  = 2'd1;
	localparam logic [1:0] KIND_LINE = 2'd2;

	localparam logic [2:0] CLASS_NONE    = 3'd0;
	localparam logic [2:0] CLASS_OPEN    = 3'd0;
	localparam logic [2:0] CLASS_CLOSE   = 3'd1;
	localparam logic [2:0] CLASS_EQUALS  = 3'd2;
	localparam logic [2:0] CLASS_COMMENT = 3'd3;
	localparam logic [2:0] CLASS_WORD    = 3'd4;
	localparam logic [2:0] CLASS_VALUE   = 3'd5;

	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_EQUALS = 8'h3D;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_DOT    = 8'h2E;

	typedef enum logic [4:0] {
		MODE_IDLE    = 5'b00001,
		MODE_WORD    = 5'b00010,
		MODE_QUOTED  = 5'b00100,
		MODE_ESCAPE  = 5'b01000,
		MODE_COMMENT = 5'b10000
	} scan_mode_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] ch;
		logic [2:0] cls;
		logic       last;
	} result_t;

	// All results caused by one input item, in emission order from entry 0.
	typedef struct packed {
		logic [CNT_W-1:0]             cnt;
		result_t [MAX_RESULTS-1:0]    ent;
	} plan_t;

	typedef struct packed {
		scan_mode_t mode;
		logic       val_flag;
	} front_status_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

	function automatic logic is_blank(input logic [7:0] c);
		return (c >= 8'd9 && c <= 8'd13) || c == 8'd32 || c == 8'd133 || c == 8'd160;
	endfunction

endpackage

// File: rtl/clt_front.sv
module clt_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      take,
	input  logic [7:0]                char_code,
	input  logic                      has_char,
	input  logic                      line_end,
	output logic                      push,
	output clt_pkg::plan_t            plan,
	output clt_pkg::front_status_t    status
);
	import clt_pkg::*;

	scan_mode_t mode_q, mode_n;
	logic       vo_q, vo_n;

	always_comb begin
		logic [CNT_W-1:0] cnt;
		logic             restart;
		logic             blank;
		logic             cut;
		cnt = '0;
		restart = 1'b0;
		blank = is_blank(char_code);
		cut = blank || char_code == CH_LBRACE || char_code == CH_RBRACE
			|| char_code == CH_EQUALS || char_code == CH_HASH;
		mode_n = mode_q;
		vo_n = vo_q;
		plan = '0;

		if (has_char) begin
			unique case (mode_q)
				MODE_WORD: begin
					if (cut) begin
						plan.ent[cnt[IDX_W-1:0]] = '{kind: KIND_END, ch: 8'd0,
							cls: vo_q ? CLASS_VALUE : CLASS_WORD, last: 1'b0};
						cnt = cnt + CNT_W'(1);
						vo_n = 1'b0;
						mode_n = MODE_IDLE;
						restart = 1'b1;
					end else begin
						plan.ent[cnt[IDX_W-1:0]] = '{kind: KIND_CHAR, ch: char_code,
							cls: CLASS_NONE, last: 1'b0};
						cnt = cnt + CNT_W'(1);
						if (char_code == CH_BSLASH || char_code == CH_DOT) begin
							vo_n = 1'b1;
						end else if (char_code == CH_QUOTE) begin
							mode_n = MODE_QUOTED;
						end
					end
				end
				MODE_QUOTED: begin
					plan.ent[cnt[IDX_W-1:0]] = '{kind: KIND_CHAR, ch: char_code,
						cls: CLASS_NONE, last: 1'b0};
					cnt = cnt + CNT_W'(1);
					if (char_code == CH_QUOTE) begin
						mode_n = MODE_WORD;
					end else if (char_code == CH_BSLASH) begin
						mode_n = MODE_ESCAPE;
					end
				end
				MODE_ESCAPE: begin
					plan.ent[cnt[IDX_W-1:0]] = '{kind: KIND_CHAR, ch: char_code,
						cls: CLASS_NONE, last: 1'b0};
					cnt = cnt + CNT_W'(1);
					mode_n = MODE_QUOTED;
				end
				MODE_COMMENT: begin
					plan.ent[cnt[IDX_W-1:0]] = '{kind: KIND_CHAR, ch: char_code,
						cls: CLASS_NONE, last: 1'b0};
					cnt = cnt + CNT_W'(1);
				end
				default: begin
					mode_n = MODE_IDLE;
					restart = 1'b1;
				end
			endcase

			// Start a new token from the idle state.
			if (restart && !blank) begin
				plan.ent[cnt[IDX_W-1:0]] = '{kind: KIND_CHAR, ch: char_code,
					cls: CLASS_NONE, last: 1'b0};
				cnt = cnt + CNT_W'(1);
				priority if (char_code == CH_LBRACE) begin
					plan.ent[cnt[IDX_W-1:0]] = '{kind: KIND_END, ch: 8'd0,
						cls: CLASS_OPEN, last: 1'b0};
					cnt = cnt + CNT_W'(1);
				end else if (char_code == CH_RBRACE) begin
					plan.ent[cnt[IDX_W-1:0]] = '{kind: KIND_END, ch: 8'd0,
						cls: CLASS_CLOSE, last: 1'b0};
					cnt = cnt + CNT_W'(1);
				end else if (char_code == CH_EQUALS) begin
					plan.ent[cnt[IDX_W-1:0]] = '{kind: KIND_END, ch: 8'd0,
						cls: CLASS_EQUALS, last: 1'b0};
					cnt = cnt + CNT_W'(1);
				end else if (char_code == CH_HASH) begin
					mode_n = MODE_COMMENT;
				end else begin
					vo_n = char_code == CH_BSLASH || char_code == CH_DOT;
					mode_n = (char_code == CH_QUOTE) ? MODE_QUOTED : MODE_WORD;
				end
			end
		end

		if (line_end) begin
			if (mode_n == MODE_WORD || mode_n == MODE_QUOTED || mode_n == MODE_ESCAPE) begin
				plan.ent[cnt[IDX_W-1:0]] = '{kind: KIND_END, ch: 8'd0,
					cls: vo_n ? CLASS_VALUE : CLASS_WORD, last: 1'b0};
				cnt = cnt + CNT_W'(1);
			end else if (mode_n == MODE_COMMENT) begin
				plan.ent[cnt[IDX_W-1:0]] = '{kind: KIND_END, ch: 8'd0,
					cls: CLASS_COMMENT, last: 1'b0};
				cnt = cnt + CNT_W'(1);
			end
			plan.ent[cnt[IDX_W-1:0]] = '{kind: KIND_LINE, ch: 8'd0,
				cls: CLASS_NONE, last: 1'b0};
			cnt = cnt + CNT_W'(1);
			mode_n = MODE_IDLE;
			vo_n = 1'b0;
		end

		// Mark the final result of this item.
		if (cnt != '0) begin
			plan.ent[cnt[IDX_W-1:0] - IDX_W'(1)].last = 1'b1;
		end
		plan.cnt = cnt;
	end

	assign push = take && plan.cnt != '0;
	assign status = '{mode: mode_q, val_flag: vo_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			vo_q <= 1'b0;
		end else if (take) begin
			mode_q <= mode_n;
			vo_q <= vo_n;
		end
	end

endmodule

// File: rtl/clt_queue.sv
module clt_queue #(
	parameter int DEPTH = clt_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  clt_pkg::plan_t         din,
	input  logic                   pop,
	output clt_pkg::plan_t         dout,
	output clt_pkg::queue_status_t status
);
	import clt_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W_Q = $clog2(DEPTH + 1);

	plan_t              mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W_Q-1:0] count_q;
	logic               do_push;
	logic               do_pop;

	assign status.full = count_q == CNT_W_Q'(DEPTH);
	assign status.empty = count_q == '0;
	assign do_push = push && !status.full;
	assign do_pop = pop && !status.empty;
	assign dout = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CNT_W_Q'(1);
				2'b01:   count_q <= count_q - CNT_W_Q'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: rtl/clt_back.sv
module clt_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  clt_pkg::plan_t         plan,
	input  logic                   plan_avail,
	output logic                   pop,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [15:0]            m_axis_tdata,
	output logic [1:0]             m_axis_tuser,
	output logic                   m_axis_tlast
);
	import clt_pkg::*;

	plan_t            cur_q;
	logic [IDX_W-1:0] idx_q;
	logic             valid_q;
	result_t          res;
	logic             step;
	logic             done;

	assign res = cur_q.ent[idx_q];
	assign step = valid_q && m_axis_tready;
	assign done = step && res.last;
	assign pop = plan_avail && (!valid_q || done);

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata = {5'd0, res.cls, res.ch};
	assign m_axis_tuser = res.kind;
	assign m_axis_tlast = res.last;

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= plan;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q <= '0;
		end else if (pop) begin
			valid_q <= 1'b1;
			idx_q <= '0;
		end else if (done) begin
			valid_q <= 1'b0;
		end else if (step) begin
			idx_q <= idx_q + IDX_W'(1);
		end
	end

endmodule

// File: rtl/config_line_tokenizer_unit.sv
// Line tokenizer: takes one Latin-1 character per input item (tuser flags a valid
// character, tlast ends the line) and returns the tokens as a stream of results:
// token characters, a token end carrying the token class, and a line-end marker.
// The front end accepts one item every cycle while the plan queue has room; each
// item becomes a plan of up to four results. The back end sends one result per
// cycle while m_axis_tready is high, and an item with no results (skipped
// whitespace, empty item) is not queued. The first result of an item is written
// into the plan queue and then loaded into the back end's result register before
// it is valid. QUEUE_DEPTH sets how many plans may wait between the two sides.
module config_line_tokenizer_unit #(
	parameter int QUEUE_DEPTH = clt_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] char_code
	input  logic [0:0]  s_axis_tuser,  // [0] has_char
	input  logic        s_axis_tlast,  // line_end
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // [7:0] out_char, [10:8] token_class, [15:11] zero
	output logic [1:0]  m_axis_tuser,  // [1:0] result_kind
	output logic        m_axis_tlast   // last_result
);
	import clt_pkg::*;

	`include "config_line_tokenizer_unit_assert.svh"

	logic          take;
	logic          push;
	plan_t         plan_in;
	plan_t         plan_out;
	logic          pop;
	front_status_t front_st;
	queue_status_t queue_st;

	assign s_axis_tready = !queue_st.full;
	assign take = s_axis_tvalid && s_axis_tready;

	clt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.char_code (s_axis_tdata),
		.has_char  (s_axis_tuser[0]),
		.line_end  (s_axis_tlast),
		.push      (push),
		.plan      (plan_in),
		.status    (front_st)
	);

	clt_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (plan_in),
		.pop    (pop),
		.dout   (plan_out),
		.status (queue_st)
	);

	clt_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.plan          (plan_out),
		.plan_avail    (!queue_st.empty),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	// A queued plan never holds more results than an item can cause.
	`CLT_ASSERT_NOW(a_plan_count, push, plan_in.cnt <= CNT_W'(MAX_RESULTS))
	// The line-end marker closes its item.
	`CLT_ASSERT_NOW(a_line_is_last, m_axis_tvalid && m_axis_tuser == KIND_LINE, m_axis_tlast)
	// After a line end the scanner is back between tokens with a clean word flag.
	`CLT_ASSERT_NEXT(a_line_resets, take && s_axis_tlast,
		front_st.mode == MODE_IDLE && !front_st.val_flag)
	// Token characters carry no class.
	`CLT_ASSERT_NOW(a_char_no_class, m_axis_tvalid && m_axis_tuser == KIND_CHAR,
		m_axis_tdata[10:8] == CLASS_NONE)

endmodule
